// ----- rtl/aem_pkg.sv -----
// ----------------------------------------------------------------------------
// aem_pkg
// Shared constants and controller/datapath interface types for the echo mixer.
// ----------------------------------------------------------------------------
package aem_pkg;

    localparam int          MAX_DELAY_DEF   = 16384;
    localparam int          SAMPLE_W        = 16;
    localparam int          DELAY_W         = 15;
    localparam int          DIVISOR_W       = 16;
    localparam int          CFG_DATA_W      = 16;
    localparam int          CFG_INDEX_W     = 1;

    localparam logic [DELAY_W-1:0]     DEFAULT_DELAY   = DELAY_W'(8000);
    localparam logic [DIVISOR_W-1:0]   DEFAULT_DIVISOR = DIVISOR_W'(4);

    localparam logic [CFG_INDEX_W-1:0] REG_DELAY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef struct packed {
        logic capture;
        logic addr;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/aem_div.sv -----
// ----------------------------------------------------------------------------
// aem_div
// Serial restoring divider: signed 16-bit dividend by unsigned 16-bit divisor,
// one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module aem_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [aem_pkg::SAMPLE_W-1:0]  i_dividend,
    input  logic        [aem_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                                 o_busy,
    output logic signed [aem_pkg::SAMPLE_W-1:0]  o_quotient
);
    import aem_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_W + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [SAMPLE_W-1:0]  r_rem;
    logic [SAMPLE_W-1:0]  r_quo;
    logic [DIVISOR_W-1:0] r_dvs;
    logic                 r_neg;

    logic [SAMPLE_W:0]    rem_sh;
    logic                 ge;
    logic [SAMPLE_W-1:0]  mag;

    assign mag    = i_dividend[SAMPLE_W-1] ? SAMPLE_W'(-i_dividend) : i_dividend;
    assign rem_sh = {r_rem, r_quo[SAMPLE_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SAMPLE_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[SAMPLE_W-1];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? SAMPLE_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[SAMPLE_W-1:0];
            r_quo <= {r_quo[SAMPLE_W-2:0], ge};
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_neg ? SAMPLE_W'(-r_quo) : r_quo;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("divider did not start");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SAMPLE_W))
        else $error("divider step count out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && !i_start) |-> (r_dvs == '0 || {1'b0, r_rem} < {1'b0, r_dvs}))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ----- rtl/aem_datapath.sv -----
// ----------------------------------------------------------------------------
// aem_datapath
// Configuration registers, delay line memory with fill tracking, index and
// drain bookkeeping, divider and output register of the echo mixer.
// ----------------------------------------------------------------------------
module aem_datapath #(
    parameter int MAX_DELAY = aem_pkg::MAX_DELAY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  aem_pkg::t_cmd                          i_cmd,
    output aem_pkg::t_status                       o_status,
    input  logic                                   i_cfg_we,
    input  logic        [aem_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic        [aem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                   i_operation,
    input  logic signed [aem_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [aem_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                                   o_tail_last
);
    import aem_pkg::*;

    localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DW  = ($clog2(MAX_DELAY + 1) > DELAY_W) ? $clog2(MAX_DELAY + 1) : DELAY_W;
    localparam int PW  = AW + 2;

    logic [DELAY_W-1:0]          r_delay;
    logic [DIVISOR_W-1:0]        r_divisor;
    logic [AW-1:0]               r_wi;
    logic                        r_wrapped;
    logic [DELAY_W-1:0]          r_drain;
    logic                        r_op;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic                        r_rd_valid;
    logic                        r_past;
    logic                        r_last;
    logic                        r_self;
    logic signed [SAMPLE_W-1:0]  r_rdata;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_sample;
    logic                        r_out_last;

    logic signed [SAMPLE_W-1:0]  mem [MAX_DELAY];

    logic [DW-1:0]               d_eff;
    logic [PW-1:0]               pos_sum;
    logic [AW-1:0]               pos;
    logic                        past;
    logic                        wi_end;
    logic signed [SAMPLE_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]        divisor;
    logic                        div_busy;
    logic signed [SAMPLE_W-1:0]  quotient;
    logic signed [SAMPLE_W-1:0]  n_out_sample;

    assign d_eff = (DW'(r_delay) > DW'(MAX_DELAY)) ? DW'(MAX_DELAY) : DW'(r_delay);

    assign pos_sum = PW'(r_wi) + PW'(MAX_DELAY) - PW'(d_eff)
                   + ((r_op == OP_DRAIN) ? PW'(r_drain) : PW'(0));
    assign pos     = (pos_sum >= PW'(MAX_DELAY)) ? AW'(pos_sum - PW'(MAX_DELAY))
                                                 : AW'(pos_sum);
    assign past    = (r_op == OP_DRAIN) && (DW'(r_drain) >= d_eff);
    assign wi_end  = r_wi == AW'(MAX_DELAY - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= DEFAULT_DELAY;
            r_divisor <= DEFAULT_DIVISOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELAY:   r_delay   <= i_cfg_data[DELAY_W-1:0];
                REG_DIVISOR: r_divisor <= i_cfg_data[DIVISOR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi      <= '0;
            r_wrapped <= 1'b0;
            r_drain   <= '0;
        end else if (i_cmd.addr) begin
            if (r_op == OP_SAMPLE) begin
                r_wi    <= wi_end ? '0 : r_wi + 1'b1;
                r_drain <= '0;
                if (wi_end) begin
                    r_wrapped <= 1'b1;
                end
            end else if (past) begin
                r_drain <= DELAY_W'(d_eff);
            end else begin
                r_drain <= r_drain + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_x  <= i_sample_in;
        end
        if (i_cmd.addr) begin
            r_rd_valid <= r_wrapped || (pos < r_wi);
            r_past     <= past;
            r_last     <= past || (DW'(r_drain) + DW'(1) == d_eff);
            r_self     <= (r_op == OP_SAMPLE) && (d_eff == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_rdata <= mem[pos];
            if (r_op == OP_SAMPLE) begin
                mem[r_wi] <= r_x;
            end
        end
    end

    assign dividend = r_self ? r_x : (r_rd_valid ? r_rdata : '0);
    assign divisor  = (r_divisor == '0) ? DEFAULT_DIVISOR : r_divisor;

    aem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign n_out_sample = r_past ? '0
                        : ((r_op == OP_DRAIN) ? quotient : SAMPLE_W'(r_x + quotient));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= (r_op == OP_DRAIN) && r_last;
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out_sample;
    assign o_tail_last       = r_out_last;

`ifndef NO_ASSERTIONS
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("output register not loaded");
    a_wi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wi) < 32'(MAX_DELAY))
        else $error("write index beyond delay line");
    a_sample_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.addr && r_op == OP_SAMPLE) |=> r_drain == '0)
        else $error("sample item did not clear drain count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/aem_ctrl.sv -----
// ----------------------------------------------------------------------------
// aem_ctrl
// Sequencer of the echo mixer: accept, address and memory access, division,
// and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module aem_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output aem_pkg::t_cmd    o_cmd,
    input  aem_pkg::t_status i_status
);
    import aem_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.addr      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != ST_IDLE;

`ifndef NO_ASSERTIONS
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state == ST_ADDR)
        else $error("accepted transfer not sequenced");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_busy) |=> r_state == ST_DIV)
        else $error("left division before divider finished");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.addr, o_cmd.div_start, o_cmd.out_load}))
        else $error("more than one command issued");
`endif

endmodule

// ----- rtl/audio_echo_mixer_core.sv -----
// An input transfer passes through accept, address and memory access, divider start,
// division until the divider is done, and the load into the output register; output
// stalls delay the load. The input stays stalled until the result has been loaded.
// The next item is taken in the cycle after the previous result enters the output register.
// Reset is synchronous and active low; it restores the default delay and divisor.
// The delay line is not cleared: a fill mark makes never-written slots read as zero.
// ----------------------------------------------------------------------------
// audio_echo_mixer_core
// Feedforward echo comb filter over signed 16-bit audio with a drained tail.
// ----------------------------------------------------------------------------
module audio_echo_mixer_core #(
    parameter int MAX_DELAY = aem_pkg::MAX_DELAY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [aem_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic        [aem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_operation,
    input  logic signed [aem_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [aem_pkg::SAMPLE_W-1:0]    o_sample_out,
    output logic                                   o_tail_last
);
    import aem_pkg::*;

    t_cmd    cmd;
    t_status status;

    aem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    aem_datapath #(
        .MAX_DELAY (MAX_DELAY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_tail_last  (o_tail_last)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo mixer core. A scoreboard predicts each
// mixed or tail sample from the accepted transfers and compares the results
// in order, while random idling on both channels and one long output hold
// exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_top;
    import aem_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       tail_last;
    } t_mix;

    class echo_scoreboard;
        logic signed [SAMPLE_W-1:0] history [MAX_DELAY_DEF];
        int unsigned                wr_slot;
        int unsigned                tail_pos;
        logic [DELAY_W-1:0]         delay_reg;
        logic [DIVISOR_W-1:0]       divisor_reg;
        t_mix                       expected_mixes [$];
        int                         errors;

        function new();
            foreach (history[i]) history[i] = '0;
            wr_slot     = 0;
            tail_pos    = 0;
            delay_reg   = DEFAULT_DELAY;
            divisor_reg = DEFAULT_DIVISOR;
            errors      = 0;
        endfunction

        function void configure(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DELAY) begin
                delay_reg = data[DELAY_W-1:0];
            end else begin
                divisor_reg = data;
            end
        endfunction

        function int scale(int v);
            int dv;
            dv = (divisor_reg == 0) ? int'(DEFAULT_DIVISOR) : int'(divisor_reg);
            return v / dv;
        endfunction

        function void note_input(logic op, logic signed [SAMPLE_W-1:0] x);
            int unsigned d;
            int unsigned pos;
            int          held;
            int          sum;
            t_mix        r;
            d = (delay_reg > MAX_DELAY_DEF) ? MAX_DELAY_DEF : delay_reg;
            if (op == OP_SAMPLE) begin
                if (d == 0) begin
                    held = int'(x);
                end else begin
                    held = int'(history[(wr_slot + MAX_DELAY_DEF - d) % MAX_DELAY_DEF]);
                end
                sum              = int'(x) + scale(held);
                r.sample         = sum[SAMPLE_W-1:0];
                r.tail_last      = 1'b0;
                history[wr_slot] = x;
                wr_slot          = (wr_slot + 1) % MAX_DELAY_DEF;
                tail_pos         = 0;
            end else if (tail_pos >= d) begin
                tail_pos    = d;
                r.sample    = '0;
                r.tail_last = 1'b1;
            end else begin
                pos         = (wr_slot + MAX_DELAY_DEF - d + tail_pos) % MAX_DELAY_DEF;
                sum         = scale(int'(history[pos]));
                r.sample    = sum[SAMPLE_W-1:0];
                r.tail_last = (tail_pos + 1 == d);
                tail_pos++;
            end
            expected_mixes.push_back(r);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] s, logic last);
            t_mix e;
            if (expected_mixes.size() == 0) begin
                $error("unexpected result: sample_out %0d tail_last %0b", s, last);
                errors++;
                return;
            end
            e = expected_mixes.pop_front();
            if (s !== e.sample) begin
                $error("sample_out: expected %0d, actual %0d", e.sample, s);
                errors++;
            end
            if (last !== e.tail_last) begin
                $error("tail_last: expected %0b, actual %0b", e.tail_last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_mixes.size();
        endfunction
    endclass

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0]         i_cfg_index  = REG_DELAY;
    logic [CFG_DATA_W-1:0]          i_cfg_data   = '0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_stall;
    logic                           i_operation  = OP_SAMPLE;
    logic signed [SAMPLE_W-1:0]     i_sample_in  = '0;
    logic                           o_out_valid;
    logic                           i_out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0]     o_sample_out;
    logic                           o_tail_last;

    echo_scoreboard sb;
    int             items_sent = 0;
    int             gap_pct    = 25;
    int             stall_pct  = 40;
    int unsigned    cur_delay  = DEFAULT_DELAY;
    bit             hold_req   = 1'b0;

    audio_echo_mixer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_tail_last  (o_tail_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_sample_out, o_tail_last);
        end
    end

    initial begin
        int span;
        forever begin
            span = $urandom_range(1, 30);
            repeat (span) @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                span = $urandom_range(1, 15);
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_sample_in <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, smp);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] delay_word,
                              input logic [CFG_DATA_W-1:0] divisor_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_DELAY;
        i_cfg_data  <= delay_word;
        @(posedge i_clk);
        sb.configure(REG_DELAY, delay_word);
        i_cfg_index <= REG_DIVISOR;
        i_cfg_data  <= divisor_word;
        @(posedge i_clk);
        sb.configure(REG_DIVISOR, divisor_word);
        i_cfg_we  <= 1'b0;
        cur_delay = (delay_word[DELAY_W-1:0] > MAX_DELAY_DEF) ? MAX_DELAY_DEF
                                                              : delay_word[DELAY_W-1:0];
    endtask

    // Sample runs followed by drain bursts sized around the delay, so that
    // tails finish, run past their end, or get cut short by new samples.
    task automatic random_phase(input int n);
        int stop_at;
        int run;
        int span;
        stop_at = items_sent + n;
        span    = (cur_delay < 1) ? 1 : ((cur_delay > 32) ? 32 : cur_delay);
        while (items_sent < stop_at) begin
            run = $urandom_range(1, span + 4);
            if (run > stop_at - items_sent) run = stop_at - items_sent;
            repeat (run) send_item(OP_SAMPLE, rand_sample());
            run = $urandom_range(0, span + 3);
            if (run > stop_at - items_sent) run = stop_at - items_sent;
            repeat (run) send_item(OP_DRAIN, rand_sample());
        end
        settle();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_SAMPLE, 16'sh7FFF);
        send_item(OP_SAMPLE, 16'sh8000);
        send_item(OP_SAMPLE, 16'sh0000);
        send_item(OP_SAMPLE, 16'shFFFF);
        send_item(OP_DRAIN, 16'sh1234);
        settle();

        set_config(16'd2, 16'd1);
        send_item(OP_SAMPLE, 16'sh7FFF);
        send_item(OP_SAMPLE, 16'sh7FFF);
        send_item(OP_SAMPLE, 16'sh7FFF);
        send_item(OP_SAMPLE, 16'sh8000);
        repeat (3) send_item(OP_DRAIN, 16'sh0000);
        settle();

        // The delay changes between drains; the tail resumes against it.
        set_config(16'd5, 16'd1);
        send_item(OP_DRAIN, 16'shFFFF);
        settle();
        set_config(16'd1, 16'd3);
        send_item(OP_DRAIN, 16'sh0000);
        settle();

        set_config(16'd0, 16'd0);
        send_item(OP_SAMPLE, 16'sh8000);
        send_item(OP_SAMPLE, 16'sh7FFF);
        send_item(OP_DRAIN, 16'sh7FFF);
        settle();

        set_config(16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, 16'sh8000);
        send_item(OP_DRAIN, 16'sh0000);
        send_item(OP_DRAIN, 16'sh8000);
        settle();

        set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)));
        random_phase(105);
        set_config(16'($urandom_range(1, 40)), 16'($urandom()));
        random_phase(105);
        set_config(16'd0, 16'd0);
        random_phase(105);
        set_config(16'd16384, 16'd1);
        random_phase(105);

        gap_pct  = 5;
        hold_req = 1'b1;
        set_config(16'($urandom_range(1, 20)), 16'hFFFF);
        random_phase(105);

        gap_pct = 25;
        set_config(16'($urandom()), 16'($urandom()));
        random_phase(105);
        set_config(16'($urandom_range(1, 30)), 16'($urandom_range(1, 16)));
        random_phase(105);

        gap_pct   = 0;
        stall_pct = 0;
        set_config(16'($urandom_range(1, 16)), 16'($urandom_range(1, 4)));
        random_phase(105);

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
